### sv/wss_pkg.sv
// Package for the windowed sample statistics block: widths and defaults
// shared by the front end, the back end and the top level.
// No dependencies.
`default_nettype none
package wss_pkg;
    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int NUM_ENTRIES_DEF   = 16;
    localparam int ID_W     = 4;
    localparam int SAMPLE_W = 32;
    localparam int FILL_W   = 7;
    localparam int TOTAL_W  = 32;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
endpackage
`default_nettype wire

### sv/wss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/wss_front.sv
// Front end: accepts beats, drops out-of-range entries, keeps per-entry
// write position, fill and total counters, and pushes a job to the queue.
// Depends on wss_pkg.
`default_nettype none
module wss_front #(
    parameter int HISTORY_DEPTH = wss_pkg::HISTORY_DEPTH_DEF,
    parameter int NUM_ENTRIES   = wss_pkg::NUM_ENTRIES_DEF,
    parameter int POS_W         = $clog2(HISTORY_DEPTH),
    parameter int CNT_W         = $clog2(HISTORY_DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [wss_pkg::ID_W-1:0]      entry_id,
    input  wire logic [wss_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic                          q_full,
    output logic                               q_push,
    output logic [wss_pkg::ID_W-1:0]           j_id,
    output logic [wss_pkg::SAMPLE_W-1:0]       j_sample,
    output logic [POS_W-1:0]                   j_pos,
    output logic [CNT_W-1:0]                   j_fill,
    output logic [wss_pkg::TOTAL_W-1:0]        j_total
);
    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    logic [POS_W-1:0]            pos_reg   [NUM_ENTRIES];
    logic [CNT_W-1:0]            fill_reg  [NUM_ENTRIES];
    logic [wss_pkg::TOTAL_W-1:0] total_reg [NUM_ENTRIES];
    logic                        in_range;
    logic [IDX_W-1:0]            idx;
    logic                        fire;

    assign in_range = ({28'd0, entry_id} < 32'(NUM_ENTRIES));
    assign idx      = IDX_W'(entry_id);
    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready && in_range;
    assign q_push   = fire;
    assign j_id     = entry_id;
    assign j_sample = sample;
    assign j_pos    = pos_reg[idx];
    assign j_fill   = (fill_reg[idx] == CNT_W'(HISTORY_DEPTH)) ? fill_reg[idx]
                    : fill_reg[idx] + CNT_W'(1);
    assign j_total  = (total_reg[idx] == wss_pkg::TOTAL_MAX) ? total_reg[idx]
                    : total_reg[idx] + wss_pkg::TOTAL_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                pos_reg[i]   <= '0;
                fill_reg[i]  <= '0;
                total_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            pos_reg[idx]   <= (j_pos == POS_W'(HISTORY_DEPTH - 1)) ? '0
                            : j_pos + POS_W'(1);
            fill_reg[idx]  <= j_fill;
            total_reg[idx] <= j_total;
        end
    end
endmodule
`default_nettype wire

### sv/wss_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on nothing but its parameters.
`default_nettype none
module wss_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign rdata     = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### sv/wss_back.sv
// Back end: writes the sample to the ring RAM, walks the filled slots for
// min, max and sum, divides by restoring division, and holds the result.
// Depends on wss_pkg and wss_ram.
`default_nettype none
module wss_back #(
    parameter int HISTORY_DEPTH = wss_pkg::HISTORY_DEPTH_DEF,
    parameter int NUM_ENTRIES   = wss_pkg::NUM_ENTRIES_DEF,
    parameter int POS_W         = $clog2(HISTORY_DEPTH),
    parameter int CNT_W         = $clog2(HISTORY_DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_not_empty,
    output logic                               q_pop,
    input  wire logic [wss_pkg::ID_W-1:0]      j_id,
    input  wire logic [wss_pkg::SAMPLE_W-1:0]  j_sample,
    input  wire logic [POS_W-1:0]              j_pos,
    input  wire logic [CNT_W-1:0]              j_fill,
    input  wire logic [wss_pkg::TOTAL_W-1:0]   j_total,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [wss_pkg::ID_W-1:0]           entry_out,
    output logic [wss_pkg::SAMPLE_W-1:0]       window_min,
    output logic [wss_pkg::SAMPLE_W-1:0]       window_max,
    output logic [wss_pkg::SAMPLE_W-1:0]       window_avg,
    output logic [wss_pkg::FILL_W-1:0]         fill_count,
    output logic [wss_pkg::TOTAL_W-1:0]        call_total
);
    localparam int IDX_W     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    // Each entry owns a power-of-two block of slots so that the address is
    // a plain concatenation of entry index and slot.
    localparam int RAM_DEPTH = NUM_ENTRIES * (2 ** POS_W);
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int SUM_W     = wss_pkg::SAMPLE_W + CNT_W;
    localparam int DIV_W     = $clog2(SUM_W + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WRT  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                  state_reg;
    logic [IDX_W-1:0]            id_reg;
    logic [wss_pkg::ID_W-1:0]    eid_reg;
    logic [wss_pkg::SAMPLE_W-1:0] smp_reg;
    logic [POS_W-1:0]            pos_reg;
    logic [CNT_W-1:0]            fill_reg;
    logic [wss_pkg::TOTAL_W-1:0] total_reg;
    logic [CNT_W-1:0]            rd_cnt_reg;
    logic [CNT_W-1:0]            got_cnt_reg;
    logic                        rd_pend_reg;
    logic [wss_pkg::SAMPLE_W-1:0] lo_reg, hi_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [SUM_W-1:0]            rem_reg;
    logic [DIV_W-1:0]            bit_reg;
    logic                        ram_we;
    logic [ADDR_W-1:0]           waddr, raddr;
    logic [wss_pkg::SAMPLE_W-1:0] rdata;
    logic [SUM_W:0]              trial;
    logic                        reading;

    assign ram_we  = (state_reg == ST_WRT);
    assign waddr   = ADDR_W'({id_reg, pos_reg});
    assign reading = (state_reg == ST_SCAN) && (rd_cnt_reg < fill_reg);
    assign raddr   = ADDR_W'({id_reg, POS_W'(rd_cnt_reg)});
    assign trial   = {rem_reg, sum_reg[SUM_W-1]} - {1'b0, {(SUM_W - CNT_W){1'b0}}, fill_reg};

    wss_ram #(.WIDTH(wss_pkg::SAMPLE_W), .DEPTH(RAM_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (smp_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign q_pop      = (state_reg == ST_IDLE) && q_not_empty;
    assign out_valid  = (state_reg == ST_OUT);
    assign entry_out  = eid_reg;
    assign window_min = lo_reg;
    assign window_max = hi_reg;
    // After the last divide step the quotient sits in the low bits of sum_reg.
    assign window_avg = sum_reg[wss_pkg::SAMPLE_W-1:0];
    assign fill_count = wss_pkg::FILL_W'(fill_reg);
    assign call_total = total_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                id_reg    <= IDX_W'(j_id);
                eid_reg   <= j_id;
                smp_reg   <= j_sample;
                pos_reg   <= j_pos;
                fill_reg  <= j_fill;
                total_reg <= j_total;
                rd_cnt_reg  <= '0;
                got_cnt_reg <= '0;
                sum_reg   <= '0;
            end
            ST_SCAN:
            begin
                if (rd_pend_reg)
                begin
                    if (got_cnt_reg == '0 || rdata < lo_reg)
                    begin
                        lo_reg <= rdata;
                    end
                    if (got_cnt_reg == '0 || rdata > hi_reg)
                    begin
                        hi_reg <= rdata;
                    end
                    sum_reg     <= sum_reg + SUM_W'(rdata);
                    got_cnt_reg <= got_cnt_reg + CNT_W'(1);
                end
                if (reading)
                begin
                    rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                end
                rem_reg <= '0;
                bit_reg <= DIV_W'(SUM_W);
            end
            ST_DIV:
            begin
                if (!trial[SUM_W])
                begin
                    rem_reg <= trial[SUM_W-1:0];
                end
                else
                begin
                    rem_reg <= {rem_reg[SUM_W-2:0], sum_reg[SUM_W-1]};
                end
                sum_reg <= {sum_reg[SUM_W-2:0], !trial[SUM_W]};
                bit_reg <= bit_reg - DIV_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= reading;
            unique case (state_reg)
                ST_IDLE: if (q_not_empty) state_reg <= ST_WRT;
                ST_WRT:  state_reg <= ST_SCAN;
                ST_SCAN:
                begin
                    if (!reading && !rd_pend_reg && got_cnt_reg == fill_reg)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:  if (bit_reg == DIV_W'(1)) state_reg <= ST_OUT;
                ST_OUT:  if (out_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### sv/windowed_sample_statistics_unit.sv
// Windowed sample statistics unit.
// Input channel (in_valid/in_ready) carries one beat: an entry index and a
// Q16.16 duration sample. The sample is stored in that entry's ring of recent
// samples and one result beat comes out on out_valid/out_ready: minimum,
// maximum and truncated average over the filled window, fill count and the
// saturating record total. Beats with an entry index of NUM_ENTRIES or more
// are accepted and dropped without a result.
// The front end updates per-entry counters in the accept cycle and queues a
// job in a two-deep queue. The back end writes the ring RAM, reads each
// filled slot once (one RAM read port, one slot a cycle), then runs a
// restoring divider one quotient bit a cycle. The back end takes the next
// job from the queue only after the receiver has taken the current result.
// Reset clears write positions, fill counts and totals; ring contents are
// never cleared since only written slots are read. When the receiver stalls
// the result holds, the back end waits, and the front end keeps accepting
// until the queue is full.
// Depends on wss_pkg, wss_front, wss_queue, wss_back, wss_ram.
`default_nettype none
module windowed_sample_statistics_unit #(
    parameter int HISTORY_DEPTH = wss_pkg::HISTORY_DEPTH_DEF,
    parameter int NUM_ENTRIES   = wss_pkg::NUM_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [wss_pkg::ID_W-1:0]      entry_id,
    input  wire logic [wss_pkg::SAMPLE_W-1:0]  sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [wss_pkg::ID_W-1:0]           entry_out,
    output logic [wss_pkg::SAMPLE_W-1:0]       window_min,
    output logic [wss_pkg::SAMPLE_W-1:0]       window_max,
    output logic [wss_pkg::SAMPLE_W-1:0]       window_avg,
    output logic [wss_pkg::FILL_W-1:0]         fill_count,
    output logic [wss_pkg::TOTAL_W-1:0]        call_total
);
    localparam int POS_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int JOB_W = wss_pkg::ID_W + wss_pkg::SAMPLE_W + POS_W + CNT_W
                         + wss_pkg::TOTAL_W;

    typedef struct packed {
        logic [wss_pkg::ID_W-1:0]     id;
        logic [wss_pkg::SAMPLE_W-1:0] smp;
        logic [POS_W-1:0]             pos;
        logic [CNT_W-1:0]             fill;
        logic [wss_pkg::TOTAL_W-1:0]  total;
    } job_t;

    job_t push_job, pop_job;
    logic q_full, q_push, q_pop, q_not_empty;
    logic [JOB_W-1:0] pop_bits;

    wss_front #(.HISTORY_DEPTH(HISTORY_DEPTH), .NUM_ENTRIES(NUM_ENTRIES)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .entry_id (entry_id),
        .sample   (sample),
        .q_full   (q_full),
        .q_push   (q_push),
        .j_id     (push_job.id),
        .j_sample (push_job.smp),
        .j_pos    (push_job.pos),
        .j_fill   (push_job.fill),
        .j_total  (push_job.total)
    );

    wss_queue #(.WIDTH(JOB_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (pop_bits)
    );

    assign pop_job = job_t'(pop_bits);

    wss_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .NUM_ENTRIES(NUM_ENTRIES)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .j_id        (pop_job.id),
        .j_sample    (pop_job.smp),
        .j_pos       (pop_job.pos),
        .j_fill      (pop_job.fill),
        .j_total     (pop_job.total),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .entry_out   (entry_out),
        .window_min  (window_min),
        .window_max  (window_max),
        .window_avg  (window_avg),
        .fill_count  (fill_count),
        .call_total  (call_total)
    );

    // A result never reports an empty window or an overfull one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill_count != '0 &&
                       32'(fill_count) <= 32'(HISTORY_DEPTH)))
        else $error("fill count out of range");

    // The window bounds are ordered and the average lies between them.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (window_min <= window_avg && window_avg <= window_max))
        else $error("average outside window bounds");

    // The queue is never pushed when full.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue overflow");
endmodule
`default_nettype wire

### bench/tb.sv
// Testbench for windowed_sample_statistics_unit: directed, saturation, backpressure
// and random tests, all checked against an in-bench model of the per-entry rings.
// Depends on wss_pkg and the unit with its submodules.
`timescale 1ns / 1ps
module tb;
    localparam int DEPTH   = wss_pkg::HISTORY_DEPTH_DEF;
    localparam int ENTRIES = wss_pkg::NUM_ENTRIES_DEF;

    typedef struct packed {
        logic [wss_pkg::ID_W-1:0]     entry;
        logic [wss_pkg::SAMPLE_W-1:0] lo;
        logic [wss_pkg::SAMPLE_W-1:0] hi;
        logic [wss_pkg::SAMPLE_W-1:0] avg;
        logic [wss_pkg::FILL_W-1:0]   fill;
        logic [wss_pkg::TOTAL_W-1:0]  total;
    } window_stats_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [wss_pkg::ID_W-1:0]     entry_id;
    logic [wss_pkg::SAMPLE_W-1:0] sample;
    logic                         out_valid;
    logic                         out_ready;
    logic [wss_pkg::ID_W-1:0]     entry_out;
    logic [wss_pkg::SAMPLE_W-1:0] window_min;
    logic [wss_pkg::SAMPLE_W-1:0] window_max;
    logic [wss_pkg::SAMPLE_W-1:0] window_avg;
    logic [wss_pkg::FILL_W-1:0]   fill_count;
    logic [wss_pkg::TOTAL_W-1:0]  call_total;

    windowed_sample_statistics_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .entry_id   (entry_id),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .entry_out  (entry_out),
        .window_min (window_min),
        .window_max (window_max),
        .window_avg (window_avg),
        .fill_count (fill_count),
        .call_total (call_total)
    );

    // Shadow copy of the per-entry history rings and counters.
    logic [wss_pkg::SAMPLE_W-1:0] hist_ring [ENTRIES][DEPTH];
    int unsigned                  hist_pos  [ENTRIES];
    int unsigned                  hist_fill [ENTRIES];
    logic [wss_pkg::TOTAL_W-1:0]  hist_total[ENTRIES];

    window_stats_t pending_stats[$];
    int            mismatches;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_off_cycles;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Store one sample and work out the statistics the unit must report for it.
    function automatic window_stats_t update_window(logic [wss_pkg::ID_W-1:0] id,
                                                    logic [wss_pkg::SAMPLE_W-1:0] smp);
        window_stats_t r;
        logic [63:0]   sum;
        hist_ring[id][hist_pos[id]] = smp;
        hist_pos[id] = (hist_pos[id] + 1) % DEPTH;
        if (hist_fill[id] < DEPTH)
            hist_fill[id]++;
        if (hist_total[id] != wss_pkg::TOTAL_MAX)
            hist_total[id]++;
        sum  = 0;
        r.lo = hist_ring[id][0];
        r.hi = hist_ring[id][0];
        for (int i = 0; i < hist_fill[id]; i++)
        begin
            sum += hist_ring[id][i];
            if (hist_ring[id][i] < r.lo)
                r.lo = hist_ring[id][i];
            if (hist_ring[id][i] > r.hi)
                r.hi = hist_ring[id][i];
        end
        r.entry = id;
        r.avg   = wss_pkg::SAMPLE_W'(sum / hist_fill[id]);
        r.fill  = wss_pkg::FILL_W'(hist_fill[id]);
        r.total = hist_total[id];
        return r;
    endfunction

    // Offer one beat, with random idle gaps before it, and hold it until accepted.
    task automatic send_beat(logic [wss_pkg::ID_W-1:0] id,
                             logic [wss_pkg::SAMPLE_W-1:0] smp);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        entry_id = id;
        sample   = smp;
        forever
        begin
            #1;
            rdy = in_ready;
            @(posedge clk);
            if (rdy)
                break;
            @(negedge clk);
        end
        pending_stats.push_back(update_window(id, smp));
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (pending_stats.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [wss_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return wss_pkg::SAMPLE_W'($urandom_range(255));
            3:       return {16'($urandom_range(15)), 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Receiver: drives out_ready at the falling edge, then checks any result
    // that completes at the next rising edge against the oldest prediction.
    initial
    begin
        logic          fire;
        window_stats_t got;
        window_stats_t want;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready = 1'b0;
                hold_off_cycles--;
            end
            else
                out_ready = ($urandom_range(99) >= recv_idle_pct);
            #1;
            fire = out_valid && out_ready && rst_n;
            got  = '{entry_out, window_min, window_max, window_avg, fill_count, call_total};
            @(posedge clk);
            if (fire)
            begin
                if (pending_stats.size() == 0)
                begin
                    $display("%0t: unexpected result beat %p", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = pending_stats.pop_front();
                    if (got.entry !== want.entry)
                        $display("%0t: entry_out exp %0d got %0d", $time, want.entry, got.entry);
                    if (got.lo !== want.lo)
                        $display("%0t: window_min exp %h got %h", $time, want.lo, got.lo);
                    if (got.hi !== want.hi)
                        $display("%0t: window_max exp %h got %h", $time, want.hi, got.hi);
                    if (got.avg !== want.avg)
                        $display("%0t: window_avg exp %h got %h", $time, want.avg, got.avg);
                    if (got.fill !== want.fill)
                        $display("%0t: fill_count exp %0d got %0d", $time, want.fill, got.fill);
                    if (got.total !== want.total)
                        $display("%0t: call_total exp %0d got %0d", $time, want.total, got.total);
                    if (got !== want)
                        mismatches++;
                end
            end
        end
    end

    // Field extremes, alternating bit patterns and every entry index.
    task automatic test_directed();
        send_beat(wss_pkg::ID_W'(0), '0);
        send_beat(wss_pkg::ID_W'(0), '1);
        send_beat(wss_pkg::ID_W'(0), 32'h5555_5555);
        send_beat(wss_pkg::ID_W'(0), 32'hAAAA_AAAA);
        send_beat(wss_pkg::ID_W'(ENTRIES - 1), '1);
        send_beat(wss_pkg::ID_W'(ENTRIES - 1), '1);
        for (int e = 1; e < ENTRIES; e++)
            send_beat(wss_pkg::ID_W'(e), {e[15:0], 16'h8000});
        wait_drained();
    endtask

    // Push one entry past the window depth so the fill count saturates and
    // the write position wraps over old samples.
    task automatic test_fill_saturation();
        for (int i = 0; i < DEPTH + 8; i++)
            send_beat(wss_pkg::ID_W'(3), (i < DEPTH) ? '1 : wss_pkg::SAMPLE_W'(i));
        wait_drained();
    endtask

    // Long receiver stall while beats keep coming, so the input stalls too.
    task automatic test_backpressure();
        hold_off_cycles = 600;
        for (int i = 0; i < 8; i++)
            send_beat(wss_pkg::ID_W'($urandom_range(ENTRIES - 1)), random_sample());
        wait_drained();
    endtask

    // Random beats, mostly on a few hot entries so windows fill and wrap.
    task automatic test_random(int count);
        logic [wss_pkg::ID_W-1:0] id;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) != 0)
                id = wss_pkg::ID_W'($urandom_range(3));
            else
                id = wss_pkg::ID_W'($urandom_range(ENTRIES - 1));
            send_beat(id, random_sample());
        end
    endtask

    initial
    begin
        in_valid        = 1'b0;
        entry_id        = '0;
        sample          = '0;
        rst_n           = 1'b0;
        mismatches      = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_off_cycles = 0;
        for (int e = 0; e < ENTRIES; e++)
        begin
            hist_pos[e]   = 0;
            hist_fill[e]  = 0;
            hist_total[e] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_fill_saturation();
        test_backpressure();
        send_idle_pct = 17;
        recv_idle_pct = 69;
        test_random(370);
        send_idle_pct = 69;
        recv_idle_pct = 17;
        test_random(370);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(370);

        wait_drained();
        repeat (150) @(posedge clk);
        if (mismatches == 0 && pending_stats.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #(8 * 3_000_000);
        $display("tb: FAIL");
        $finish;
    end
endmodule
